FILE: design/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types and constants of the C-subset lexer: payload structs, token
// kinds, error codes and the keyword table.
// ----------------------------------------------------------------------------
package csl_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_source;
    } in_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [1:0]  error_code;
        logic [15:0] line_number;
        logic [15:0] column_number;
        logic [30:0] number_value;
        logic [23:0] lexeme_start;
        logic [15:0] lexeme_length;
        logic        last;
    } out_t;

    // Up to two tokens produced by one input transfer, in order.
    typedef struct packed {
        logic [1:0] count;
        out_t       first;
        out_t       second;
    } step_res_t;

    localparam logic [4:0] KIND_END    = 5'd0;
    localparam logic [4:0] KIND_IDENT  = 5'd1;
    localparam logic [4:0] KIND_NUMBER = 5'd2;
    localparam logic [4:0] KIND_INT    = 5'd3;
    localparam logic [4:0] KIND_LPAREN = 5'd11;
    localparam logic [4:0] KIND_RPAREN = 5'd12;
    localparam logic [4:0] KIND_LBRACE = 5'd13;
    localparam logic [4:0] KIND_RBRACE = 5'd14;
    localparam logic [4:0] KIND_LBRACK = 5'd15;
    localparam logic [4:0] KIND_RBRACK = 5'd16;
    localparam logic [4:0] KIND_SEMI   = 5'd17;
    localparam logic [4:0] KIND_COMMA  = 5'd18;
    localparam logic [4:0] KIND_PLUS   = 5'd19;
    localparam logic [4:0] KIND_MINUS  = 5'd20;
    localparam logic [4:0] KIND_STAR   = 5'd21;
    localparam logic [4:0] KIND_SLASH  = 5'd22;
    localparam logic [4:0] KIND_ASSIGN = 5'd23;
    localparam logic [4:0] KIND_EQ     = 5'd24;
    localparam logic [4:0] KIND_NE     = 5'd25;
    localparam logic [4:0] KIND_LT     = 5'd26;
    localparam logic [4:0] KIND_LE     = 5'd27;
    localparam logic [4:0] KIND_GT     = 5'd28;
    localparam logic [4:0] KIND_GE     = 5'd29;
    localparam logic [4:0] KIND_ERROR  = 5'd30;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_BYTE = 2'd1;
    localparam logic [1:0] ERR_BANG     = 2'd2;
    localparam logic [1:0] ERR_TOO_BIG  = 2'd3;

    localparam int          NUM_KEYWORDS = 8;
    localparam logic [30:0] NUM_MAX      = 31'h7FFF_FFFF;

    // Keyword text packed first byte lowest, in kind order starting at KIND_INT.
    function automatic logic [63:0] kw_text(input logic [2:0] k);
        logic [63:0] t;
        case (k)
            3'd0:    t = 64'h0000_0000_0074_6E69; // int
            3'd1:    t = 64'h0000_0000_6469_6F76; // void
            3'd2:    t = 64'h0000_0000_0000_6669; // if
            3'd3:    t = 64'h0000_0000_6573_6C65; // else
            3'd4:    t = 64'h0000_0065_6C69_6877; // while
            3'd5:    t = 64'h0000_6E72_7574_6572; // return
            3'd6:    t = 64'h0000_0074_7570_6E69; // input
            3'd7:    t = 64'h0000_7475_7074_756F; // output
            default: t = 64'h0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_len(input logic [2:0] k);
        logic [3:0] n;
        case (k)
            3'd0:    n = 4'd3;
            3'd1:    n = 4'd4;
            3'd2:    n = 4'd2;
            3'd3:    n = 4'd4;
            3'd4:    n = 4'd5;
            3'd5:    n = 4'd6;
            3'd6:    n = 4'd5;
            3'd7:    n = 4'd6;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: design/csl_scan.sv
// ----------------------------------------------------------------------------
// csl_scan
// Scanner state and the single-pass next-state logic: one source byte per
// transfer, up to two tokens out.
// ----------------------------------------------------------------------------
module csl_scan #(
    parameter int INDEX_BITS        = 24,
    parameter int POSITION_BITS     = 16,
    parameter int KEYWORD_MAX_CHARS = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  csl_pkg::in_t        in_data,
    output csl_pkg::step_res_t  res
);

    localparam int KW_BITS = 8 * KEYWORD_MAX_CHARS;

    localparam logic [3:0] MODE_IDLE    = 4'd0;
    localparam logic [3:0] MODE_IDENT   = 4'd1;
    localparam logic [3:0] MODE_NUMBER  = 4'd2;
    localparam logic [3:0] MODE_SLASH   = 4'd3;
    localparam logic [3:0] MODE_COMMENT = 4'd4;
    localparam logic [3:0] MODE_BANG    = 4'd5;
    localparam logic [3:0] MODE_EQ      = 4'd6;
    localparam logic [3:0] MODE_LT      = 4'd7;
    localparam logic [3:0] MODE_GT      = 4'd8;

    localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};
    localparam logic [INDEX_BITS-1:0]    IDX_ONE = {{(INDEX_BITS-1){1'b0}}, 1'b1};

    logic [3:0]               mode_reg,  mode_next;
    logic [POSITION_BITS-1:0] line_reg,  line_next;
    logic [POSITION_BITS-1:0] col_reg,   col_next;
    logic [INDEX_BITS-1:0]    src_reg,   src_next;
    logic [INDEX_BITS-1:0]    tsi_reg,   tsi_next;
    logic [POSITION_BITS-1:0] tsc_reg,   tsc_next;
    logic [POSITION_BITS-1:0] tlen_reg,  tlen_next;
    logic [KW_BITS-1:0]       kw_reg,    kw_next;
    logic [30:0]              acc_reg,   acc_next;
    logic                     ovf_reg,   ovf_next;

    logic [7:0]   c;
    logic         is_dig;
    logic         is_alp;
    logic [4:0]   id_kind;
    logic [34:0]  acc_mul;
    logic         flush_vld;
    csl_pkg::out_t flush_res;
    logic         tok_vld;
    csl_pkg::out_t tok_res;
    logic [4:0]   single_kind;

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        return (&v) ? v : v + POS_ONE;
    endfunction

    function automatic logic [15:0] pos_field(input logic [POSITION_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    function automatic logic [23:0] idx_field(input logic [INDEX_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[23:0];
    endfunction

    function automatic csl_pkg::out_t make_tok(
        input logic [4:0]               kind,
        input logic [1:0]               err,
        input logic [POSITION_BITS-1:0] line,
        input logic [POSITION_BITS-1:0] col,
        input logic [30:0]              value,
        input logic [INDEX_BITS-1:0]    start,
        input logic [POSITION_BITS-1:0] len
    );
        csl_pkg::out_t t;
        t.token_kind    = kind;
        t.error_code    = err;
        t.line_number   = pos_field(line);
        t.column_number = pos_field(col);
        t.number_value  = value;
        t.lexeme_start  = idx_field(start);
        t.lexeme_length = pos_field(len);
        t.last          = 1'b0;
        return t;
    endfunction

    assign c      = in_data.char_code;
    assign is_dig = (c >= 8'h30) && (c <= 8'h39);
    assign is_alp = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
                    || (c == 8'h5F);

    // acc * 10 + digit; acc never exceeds NUM_MAX so 35 bits hold it
    assign acc_mul = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {31'd0, c[3:0]};

    always_comb begin
        id_kind = csl_pkg::KIND_IDENT;
        if (tlen_reg <= POSITION_BITS'(KEYWORD_MAX_CHARS)) begin
            for (int k = 0; k < csl_pkg::NUM_KEYWORDS; k++) begin
                if (POSITION_BITS'(csl_pkg::kw_len(3'(k))) == tlen_reg
                        && csl_pkg::kw_text(3'(k)) == 64'(kw_reg)) begin
                    id_kind = 5'(csl_pkg::KIND_INT + 5'(k));
                end
            end
        end
    end

    // Token held by the current mode, emitted when a byte ends it
    always_comb begin
        flush_vld = 1'b1;
        flush_res = make_tok(csl_pkg::KIND_SLASH, csl_pkg::ERR_NONE, line_reg, tsc_reg,
                             31'd0, tsi_reg, POS_ONE);
        case (mode_reg)
            MODE_IDENT: begin
                flush_res.token_kind    = id_kind;
                flush_res.lexeme_length = pos_field(tlen_reg);
            end
            MODE_NUMBER: begin
                flush_res.token_kind    = csl_pkg::KIND_NUMBER;
                flush_res.error_code    = ovf_reg ? csl_pkg::ERR_TOO_BIG : csl_pkg::ERR_NONE;
                flush_res.number_value  = ovf_reg ? 31'd0 : acc_reg;
                flush_res.lexeme_length = pos_field(tlen_reg);
            end
            MODE_SLASH: flush_res.token_kind = csl_pkg::KIND_SLASH;
            MODE_BANG: begin
                flush_res.token_kind = csl_pkg::KIND_ERROR;
                flush_res.error_code = csl_pkg::ERR_BANG;
            end
            MODE_EQ:   flush_res.token_kind = csl_pkg::KIND_ASSIGN;
            MODE_LT:   flush_res.token_kind = csl_pkg::KIND_LT;
            MODE_GT:   flush_res.token_kind = csl_pkg::KIND_GT;
            default:   flush_vld = 1'b0;
        endcase
    end

    always_comb begin
        case (c)
            8'h28:   single_kind = csl_pkg::KIND_LPAREN;
            8'h29:   single_kind = csl_pkg::KIND_RPAREN;
            8'h7B:   single_kind = csl_pkg::KIND_LBRACE;
            8'h7D:   single_kind = csl_pkg::KIND_RBRACE;
            8'h5B:   single_kind = csl_pkg::KIND_LBRACK;
            8'h5D:   single_kind = csl_pkg::KIND_RBRACK;
            8'h3B:   single_kind = csl_pkg::KIND_SEMI;
            8'h2C:   single_kind = csl_pkg::KIND_COMMA;
            8'h2B:   single_kind = csl_pkg::KIND_PLUS;
            8'h2D:   single_kind = csl_pkg::KIND_MINUS;
            8'h2A:   single_kind = csl_pkg::KIND_STAR;
            default: single_kind = csl_pkg::KIND_END;
        endcase
    end

    always_comb begin
        mode_next = mode_reg;
        line_next = line_reg;
        col_next  = col_reg;
        src_next  = src_reg;
        tsi_next  = tsi_reg;
        tsc_next  = tsc_reg;
        tlen_next = tlen_reg;
        kw_next   = kw_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        tok_vld   = 1'b0;
        tok_res   = flush_res;
        res.count  = 2'd0;
        res.first  = flush_res;
        res.second = flush_res;

        if (step) begin
            if (in_data.end_of_source) begin
                tok_res = make_tok(csl_pkg::KIND_END, csl_pkg::ERR_NONE, line_reg,
                                   sat_inc(col_reg), 31'd0, src_reg, '0);
                tok_res.last = 1'b1;
                if (flush_vld) begin
                    res.count  = 2'd2;
                    res.second = tok_res;
                end else begin
                    res.count = 2'd1;
                    res.first = tok_res;
                end
                // whole scanner back to its reset state
                mode_next = MODE_IDLE;
                line_next = POS_ONE;
                col_next  = '0;
                src_next  = '0;
                tsi_next  = '0;
                tsc_next  = POS_ONE;
                tlen_next = '0;
                kw_next   = '0;
                acc_next  = '0;
                ovf_next  = 1'b0;
            end else begin
                src_next = src_reg + IDX_ONE;
                if (mode_reg == MODE_IDENT && (is_alp || is_dig)) begin
                    for (int i = 0; i < KEYWORD_MAX_CHARS; i++) begin
                        if (tlen_reg == POSITION_BITS'(i)) begin
                            kw_next[8*i +: 8] = c;
                        end
                    end
                    tlen_next = sat_inc(tlen_reg);
                    col_next  = sat_inc(col_reg);
                end else if (mode_reg == MODE_NUMBER && is_dig) begin
                    if (!ovf_reg) begin
                        if (acc_mul > 35'(csl_pkg::NUM_MAX)) begin
                            ovf_next = 1'b1;
                            acc_next = '0;
                        end else begin
                            acc_next = acc_mul[30:0];
                        end
                    end
                    tlen_next = sat_inc(tlen_reg);
                    col_next  = sat_inc(col_reg);
                end else if (mode_reg == MODE_SLASH && c == 8'h2F) begin
                    mode_next = MODE_COMMENT;
                    col_next  = sat_inc(col_reg);
                end else if (mode_reg == MODE_COMMENT) begin
                    if (c == 8'h0A) begin
                        mode_next = MODE_IDLE;
                        line_next = sat_inc(line_reg);
                        col_next  = '0;
                    end else begin
                        col_next = sat_inc(col_reg);
                    end
                end else if (c == 8'h3D && mode_reg >= MODE_BANG && mode_reg <= MODE_GT) begin
                    // two-character comparison operator
                    res.count = 2'd1;
                    res.first = make_tok(csl_pkg::KIND_NE, csl_pkg::ERR_NONE, line_reg,
                                         tsc_reg, 31'd0, tsi_reg, POS_ONE + POS_ONE);
                    case (mode_reg)
                        MODE_EQ: res.first.token_kind = csl_pkg::KIND_EQ;
                        MODE_LT: res.first.token_kind = csl_pkg::KIND_LE;
                        MODE_GT: res.first.token_kind = csl_pkg::KIND_GE;
                        default: res.first.token_kind = csl_pkg::KIND_NE;
                    endcase
                    res.first.last = 1'b1;
                    col_next  = sat_inc(col_reg);
                    mode_next = MODE_IDLE;
                end else begin
                    // pending token ends here; the byte is scanned from idle
                    mode_next = MODE_IDLE;
                    if (c == 8'h20 || c == 8'h09 || c == 8'h0D) begin
                        col_next = sat_inc(col_reg);
                    end else if (c == 8'h0A) begin
                        line_next = sat_inc(line_reg);
                        col_next  = '0;
                    end else begin
                        tsi_next  = src_reg;
                        tsc_next  = sat_inc(col_reg);
                        tlen_next = POS_ONE;
                        col_next  = sat_inc(col_reg);
                        tok_res   = make_tok(single_kind, csl_pkg::ERR_NONE, line_reg,
                                             sat_inc(col_reg), 31'd0, src_reg, POS_ONE);
                        if (single_kind != csl_pkg::KIND_END) begin
                            tok_vld = 1'b1;
                        end else if (c == 8'h2F) begin
                            mode_next = MODE_SLASH;
                        end else if (c == 8'h3D) begin
                            mode_next = MODE_EQ;
                        end else if (c == 8'h3C) begin
                            mode_next = MODE_LT;
                        end else if (c == 8'h3E) begin
                            mode_next = MODE_GT;
                        end else if (c == 8'h21) begin
                            mode_next = MODE_BANG;
                        end else if (is_dig) begin
                            mode_next = MODE_NUMBER;
                            acc_next  = {27'd0, c[3:0]};
                            ovf_next  = 1'b0;
                        end else if (is_alp) begin
                            mode_next = MODE_IDENT;
                            kw_next   = KW_BITS'(c);
                        end else begin
                            tok_vld            = 1'b1;
                            tok_res.token_kind = csl_pkg::KIND_ERROR;
                            tok_res.error_code = csl_pkg::ERR_BAD_BYTE;
                        end
                    end
                    tok_res.last = 1'b1;
                    if (flush_vld) begin
                        res.count  = tok_vld ? 2'd2 : 2'd1;
                        res.first  = flush_res;
                        res.first.last = !tok_vld;
                        res.second = tok_res;
                    end else begin
                        res.count = tok_vld ? 2'd1 : 2'd0;
                        res.first = tok_res;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            line_reg <= POS_ONE;
            col_reg  <= '0;
            src_reg  <= '0;
            tsi_reg  <= '0;
            tsc_reg  <= POS_ONE;
            tlen_reg <= '0;
            kw_reg   <= '0;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            src_reg  <= src_next;
            tsi_reg  <= tsi_next;
            tsc_reg  <= tsc_next;
            tlen_reg <= tlen_next;
            kw_reg   <= kw_next;
            acc_reg  <= acc_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

FILE: design/csl_outq.sv
// ----------------------------------------------------------------------------
// csl_outq
// Three-entry token queue between the scanner and the result channel.
// Head entry drives the output; up to two tokens are written per cycle.
// ----------------------------------------------------------------------------
module csl_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  csl_pkg::step_res_t push,
    output logic               in_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output csl_pkg::out_t      m_data
);

    localparam int DEPTH = 3;

    csl_pkg::out_t q_reg  [DEPTH];
    csl_pkg::out_t q_next [DEPTH];
    csl_pkg::out_t sh     [DEPTH];
    logic [1:0]    count_reg, count_next;
    logic          pop;
    logic [1:0]    base;

    assign m_valid  = (count_reg != 2'd0);
    assign m_data   = q_reg[0];
    assign pop      = m_valid && m_ready;
    // room for two tokens regardless of the output side this cycle
    assign in_ready = (count_reg <= 2'd1);
    assign base     = count_reg - {1'b0, pop};

    always_comb begin
        sh[0] = pop ? q_reg[1] : q_reg[0];
        sh[1] = pop ? q_reg[2] : q_reg[1];
        sh[2] = q_reg[2];
        for (int i = 0; i < DEPTH; i++) begin
            if (2'(i) < base) begin
                q_next[i] = sh[i];
            end else if (2'(i) == base && push.count != 2'd0) begin
                q_next[i] = push.first;
            end else if (2'(i) == base + 2'd1 && push.count == 2'd2) begin
                q_next[i] = push.second;
            end else begin
                q_next[i] = sh[i];
            end
        end
        count_next = base + push.count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

FILE: design/c_subset_lexer.sv
// ----------------------------------------------------------------------------
// c_subset_lexer
// Streaming lexer for a small C-like language: one source byte per cycle while
// s_ready is high; tokens out with kind, position, lexeme span, number value.
// ----------------------------------------------------------------------------
// Output: tokens are registered in the token queue; the head entry drives m_data.
// Throughput: one byte per cycle while s_ready is high; the three-entry token
//   queue drops s_ready while it holds two or more tokens.
// Reset: synchronous, active low; scanner returns to line 1, column 0,
//   index 0 and the token queue empties.
// ----------------------------------------------------------------------------
module c_subset_lexer #(
    parameter int INDEX_BITS        = 24,
    parameter int POSITION_BITS     = 16,
    parameter int KEYWORD_MAX_CHARS = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  csl_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output csl_pkg::out_t m_data
);

    logic               step;
    csl_pkg::step_res_t scan_res;

    assign step = s_valid && s_ready;

    csl_scan #(
        .INDEX_BITS        (INDEX_BITS),
        .POSITION_BITS     (POSITION_BITS),
        .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_data (s_data),
        .res     (scan_res)
    );

    csl_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (scan_res),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef SYNTHESIS
    // end of text always produces at least the end token
    a_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        step && s_data.end_of_source |=> m_valid)
        else $error("no token after end of text");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.token_kind == csl_pkg::KIND_END |-> m_data.last)
        else $error("end token without last");

    a_value_num: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.token_kind != csl_pkg::KIND_NUMBER |-> m_data.number_value == 31'd0)
        else $error("number value on non-number token");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.token_kind == csl_pkg::KIND_ERROR
            |-> m_data.error_code != csl_pkg::ERR_NONE)
        else $error("error token without error code");
`endif

endmodule

FILE: tb/c_subset_lexer_tb.sv
// ----------------------------------------------------------------------------
// c_subset_lexer_tb
// Self-checking bench for the streaming C-subset lexer. Byte streams are built
// from random tokens, comments, white space and noise. A scoreboard tracks the
// scanner state, predicts every token and checks the result stream in order.
// Both sides idle in random bursts; a closing stretch runs without idling.
// ----------------------------------------------------------------------------
typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_SLASH, SCAN_COMMENT,
    SCAN_BANG, SCAN_EQ, SCAN_LT, SCAN_GT
} scan_mode_t;

localparam logic [7:0] CH_TAB = 8'h09;
localparam logic [7:0] CH_LF  = 8'h0A;
localparam logic [7:0] CH_CR  = 8'h0D;
localparam int         WORD_BYTES = 6;

class token_scoreboard;
    csl_pkg::out_t expected_tokens[$];
    string         keyword_names[8];
    int            mismatches;
    int            tokens_checked;
    int            bytes_lexed;
    int            texts_closed;

    scan_mode_t  mode;
    logic [15:0] line_no;
    logic [15:0] col_no;
    logic [15:0] tok_col;
    logic [15:0] tok_len;
    logic [23:0] src_idx;
    logic [23:0] tok_idx;
    logic [47:0] word_bytes;
    logic [30:0] num_val;
    bit          num_big;
    int          made;

    function new();
        keyword_names = '{"int", "void", "if", "else", "while", "return", "input", "output"};
        mismatches     = 0;
        tokens_checked = 0;
        bytes_lexed    = 0;
        texts_closed   = 0;
        reset_state();
    endfunction

    function void reset_state();
        mode       = SCAN_IDLE;
        line_no    = 16'd1;
        col_no     = 16'd0;
        src_idx    = '0;
        tok_idx    = '0;
        tok_col    = 16'd1;
        tok_len    = 16'd0;
        word_bytes = '0;
        num_val    = '0;
        num_big    = 1'b0;
    endfunction

    function logic [15:0] bump(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function void push_token(logic [4:0] kind, logic [1:0] err, logic [30:0] value,
                             logic [15:0] len);
        csl_pkg::out_t t;
        t.token_kind    = kind;
        t.error_code    = err;
        t.line_number   = line_no;
        t.column_number = tok_col;
        t.number_value  = value;
        t.lexeme_start  = tok_idx;
        t.lexeme_length = len;
        t.last          = 1'b0;
        expected_tokens.push_back(t);
        made++;
    endfunction

    function logic [4:0] word_kind();
        logic [4:0] kind;
        bit         hit;
        int         k;
        int         i;
        kind = csl_pkg::KIND_IDENT;
        if (tok_len <= WORD_BYTES) begin
            for (k = 0; k < 8; k++) begin
                if (keyword_names[k].len() == tok_len) begin
                    hit = 1'b1;
                    for (i = 0; i < keyword_names[k].len(); i++) begin
                        if (word_bytes[8*i +: 8] != keyword_names[k][i])
                            hit = 1'b0;
                    end
                    if (hit)
                        kind = csl_pkg::KIND_INT + 5'(k);
                end
            end
        end
        return kind;
    endfunction

    // emit whatever token is still open, then go idle
    function void flush();
        case (mode)
            SCAN_IDENT:  push_token(word_kind(), csl_pkg::ERR_NONE, '0, tok_len);
            SCAN_NUMBER: push_token(csl_pkg::KIND_NUMBER,
                                    num_big ? csl_pkg::ERR_TOO_BIG : csl_pkg::ERR_NONE,
                                    num_big ? 31'd0 : num_val, tok_len);
            SCAN_SLASH:  push_token(csl_pkg::KIND_SLASH, csl_pkg::ERR_NONE, '0, 16'd1);
            SCAN_BANG:   push_token(csl_pkg::KIND_ERROR, csl_pkg::ERR_BANG, '0, 16'd1);
            SCAN_EQ:     push_token(csl_pkg::KIND_ASSIGN, csl_pkg::ERR_NONE, '0, 16'd1);
            SCAN_LT:     push_token(csl_pkg::KIND_LT, csl_pkg::ERR_NONE, '0, 16'd1);
            SCAN_GT:     push_token(csl_pkg::KIND_GT, csl_pkg::ERR_NONE, '0, 16'd1);
            default: ;
        endcase
        mode = SCAN_IDLE;
    endfunction

    function void start_token(logic [7:0] c);
        logic [4:0] kind;
        bit         lone;
        if (c == " " || c == CH_TAB || c == CH_CR) begin
            col_no = bump(col_no);
            return;
        end
        if (c == CH_LF) begin
            line_no = bump(line_no);
            col_no  = 16'd0;
            return;
        end
        tok_idx = src_idx;
        tok_col = bump(col_no);
        tok_len = 16'd1;
        col_no  = bump(col_no);
        lone    = 1'b1;
        kind    = csl_pkg::KIND_ERROR;
        case (c)
            "(":     kind = csl_pkg::KIND_LPAREN;
            ")":     kind = csl_pkg::KIND_RPAREN;
            "{":     kind = csl_pkg::KIND_LBRACE;
            "}":     kind = csl_pkg::KIND_RBRACE;
            "[":     kind = csl_pkg::KIND_LBRACK;
            "]":     kind = csl_pkg::KIND_RBRACK;
            ";":     kind = csl_pkg::KIND_SEMI;
            ",":     kind = csl_pkg::KIND_COMMA;
            "+":     kind = csl_pkg::KIND_PLUS;
            "-":     kind = csl_pkg::KIND_MINUS;
            "*":     kind = csl_pkg::KIND_STAR;
            default: lone = 1'b0;
        endcase
        if (lone) begin
            push_token(kind, csl_pkg::ERR_NONE, '0, 16'd1);
        end else if (c == "/") begin
            mode = SCAN_SLASH;
        end else if (c == "=") begin
            mode = SCAN_EQ;
        end else if (c == "<") begin
            mode = SCAN_LT;
        end else if (c == ">") begin
            mode = SCAN_GT;
        end else if (c == "!") begin
            mode = SCAN_BANG;
        end else if (is_digit(c)) begin
            mode    = SCAN_NUMBER;
            num_val = 31'(c - "0");
            num_big = 1'b0;
        end else if (is_alpha(c)) begin
            mode       = SCAN_IDENT;
            word_bytes = 48'(c);
        end else begin
            push_token(csl_pkg::KIND_ERROR, csl_pkg::ERR_BAD_BYTE, '0, 16'd1);
        end
    endfunction

    function void note_transfer(csl_pkg::in_t item);
        logic [7:0]    c;
        logic [35:0]   wide;
        csl_pkg::out_t t;
        made = 0;
        c    = item.char_code;
        if (item.end_of_source) begin
            flush();
            tok_idx = src_idx;
            tok_col = bump(col_no);
            push_token(csl_pkg::KIND_END, csl_pkg::ERR_NONE, '0, 16'd0);
            t = expected_tokens.pop_back();
            t.last = 1'b1;
            expected_tokens.push_back(t);
            reset_state();
            texts_closed++;
            return;
        end
        bytes_lexed++;
        if (mode == SCAN_IDENT && (is_alpha(c) || is_digit(c))) begin
            if (tok_len < WORD_BYTES)
                word_bytes[8*tok_len +: 8] = c;
            tok_len = bump(tok_len);
            col_no  = bump(col_no);
        end else if (mode == SCAN_NUMBER && is_digit(c)) begin
            if (!num_big) begin
                wide = 36'(num_val) * 36'd10 + 36'(c - "0");
                if (wide > 36'(csl_pkg::NUM_MAX)) begin
                    num_big = 1'b1;
                    num_val = '0;
                end else begin
                    num_val = wide[30:0];
                end
            end
            tok_len = bump(tok_len);
            col_no  = bump(col_no);
        end else if (mode == SCAN_SLASH && c == "/") begin
            mode   = SCAN_COMMENT;
            col_no = bump(col_no);
        end else if (mode == SCAN_COMMENT) begin
            if (c == CH_LF) begin
                mode    = SCAN_IDLE;
                line_no = bump(line_no);
                col_no  = 16'd0;
            end else begin
                col_no = bump(col_no);
            end
        end else if (c == "=" && (mode == SCAN_BANG || mode == SCAN_EQ ||
                                  mode == SCAN_LT || mode == SCAN_GT)) begin
            col_no = bump(col_no);
            push_token((mode == SCAN_BANG) ? csl_pkg::KIND_NE :
                       (mode == SCAN_EQ)   ? csl_pkg::KIND_EQ :
                       (mode == SCAN_LT)   ? csl_pkg::KIND_LE : csl_pkg::KIND_GE,
                       csl_pkg::ERR_NONE, '0, 16'd2);
            mode = SCAN_IDLE;
        end else begin
            flush();
            start_token(c);
        end
        src_idx = src_idx + 24'd1;
        if (made > 0) begin
            t = expected_tokens.pop_back();
            t.last = 1'b1;
            expected_tokens.push_back(t);
        end
    endfunction

    function string fmt_token(csl_pkg::out_t t);
        return $sformatf("kind=%0d err=%0d line=%0d col=%0d value=%0d start=%0d len=%0d last=%0d",
                         t.token_kind, t.error_code, t.line_number, t.column_number,
                         t.number_value, t.lexeme_start, t.lexeme_length, t.last);
    endfunction

    function void check_token(csl_pkg::out_t got);
        csl_pkg::out_t want;
        tokens_checked++;
        if (expected_tokens.size() == 0) begin
            if (mismatches < 10)
                $display("token %0d not expected: %s", tokens_checked, fmt_token(got));
            mismatches++;
            return;
        end
        want = expected_tokens.pop_front();
        if (got !== want) begin
            if (mismatches < 10)
                $display("token %0d mismatch\n  expected %s\n  actual   %s",
                         tokens_checked, fmt_token(want), fmt_token(got));
            mismatches++;
        end
    endfunction
endclass

module c_subset_lexer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 750;
    localparam int TAIL_ITEMS   = 90;
    localparam int CYCLE_LIMIT  = 1000000;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    csl_pkg::in_t  s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    csl_pkg::out_t m_data;

    bit              tx_gaps   = 1'b0;
    bit              rx_stalls = 1'b0;
    int              items_sent = 0;
    int unsigned     cycles     = 0;
    token_scoreboard board      = new();

    c_subset_lexer u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // input is noted before the output check, so a same-edge result is never early
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.note_transfer(s_data);
            if (m_valid && m_ready)
                board.check_token(m_data);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("c_subset_lexer_tb NOT OK");
        $finish;
    end

    initial begin
        wait (aresetn);
        forever begin
            if (rx_stalls && $urandom_range(0, 15) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic send_item(input csl_pkg::in_t item);
        if (tx_gaps && $urandom_range(0, 11) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] c);
        csl_pkg::in_t item;
        item.char_code     = c;
        item.end_of_source = 1'b0;
        send_item(item);
    endtask

    task automatic send_end();
        csl_pkg::in_t item;
        item.char_code     = 8'($urandom);
        item.end_of_source = 1'b1;
        send_item(item);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // hold the sender until every predicted token has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.expected_tokens.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] word_char(input bit with_digits);
        int unsigned r;
        r = $urandom_range(0, with_digits ? 62 : 52);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r == 52)
            return "_";
        return 8'("0" + r - 53);
    endfunction

    task automatic send_number();
        longint v;
        int     n;
        int     i;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 999);
            1: v = $urandom_range(0, 32'h7FFF_FFFF);
            2: v = longint'(csl_pkg::NUM_MAX) - 3 + $urandom_range(0, 8);
            3: begin
                n = $urandom_range(11, 14);
                for (i = 0; i < n; i++)
                    send_byte(8'("0" + $urandom_range(0, 9)));
                return;
            end
            4: begin
                send_text("00");
                v = $urandom_range(0, 99);
            end
            default: v = $urandom;
        endcase
        send_text($sformatf("%0d", v));
    endtask

    task automatic send_fragment();
        int          pick;
        int          n;
        int          i;
        logic [7:0]  c;
        string       singles;
        singles = "(){}[];,+-*/=<>!";
        pick    = $urandom_range(0, 99);
        if (pick < 18) begin
            send_text(board.keyword_names[$urandom_range(0, 7)]);
            if ($urandom_range(0, 3) == 0)
                send_byte(word_char(1'b1));
        end else if (pick < 36) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            send_byte(word_char(1'b0));
            for (i = 1; i < n; i++)
                send_byte(word_char(1'b1));
        end else if (pick < 51) begin
            send_number();
        end else if (pick < 71) begin
            send_byte(singles[$urandom_range(0, singles.len() - 1)]);
        end else if (pick < 79) begin
            send_byte(singles[$urandom_range(12, 15)]);
            send_byte("=");
        end else if (pick < 84) begin
            send_text("//");
            n = $urandom_range(0, 8);
            for (i = 0; i < n; i++) begin
                c = 8'($urandom);
                send_byte((c == CH_LF) ? "/" : c);
            end
            send_byte(CH_LF);
        end else if (pick < 92) begin
            case ($urandom_range(0, 3))
                0:       send_byte(" ");
                1:       send_byte(CH_TAB);
                2:       send_byte(CH_CR);
                default: send_byte(CH_LF);
            endcase
        end else if (pick < 95) begin
            send_byte(8'($urandom));
        end else if (pick < 98) begin
            send_end();
        end else begin
            // broken operator pairs such as "!<" or "//" glued to a token
            send_byte(singles[$urandom_range(11, 15)]);
            send_byte(singles[$urandom_range(0, 15)]);
        end
        if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 7))
                0:       send_byte(CH_LF);
                1:       send_byte(CH_TAB);
                default: send_byte(" ");
            endcase
        end
    endtask

    initial begin
        int stop_at;
        int next_switch;
        int next_drain;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // lone bang, identifier, assign then NUL, high byte, oversized number,
        // end inside a comment, number flushed by the end transfer
        send_byte("!");
        send_byte("a");
        send_byte("=");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(" ");
        send_text("2147483648");
        send_text("//c");
        send_end();
        send_byte("7");
        send_end();
        drain();

        stop_at     = items_sent + RANDOM_BYTES;
        next_switch = items_sent;
        next_drain  = items_sent + 300;
        while (items_sent < stop_at) begin
            if (items_sent >= next_switch) begin
                tx_gaps     = $urandom_range(0, 3) != 0;
                rx_stalls   = $urandom_range(0, 3) != 0;
                next_switch = items_sent + $urandom_range(40, 120);
            end
            if (items_sent >= next_drain) begin
                drain();
                next_drain = items_sent + 300;
            end
            send_fragment();
        end
        send_end();

        // no idling from here on
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        stop_at   = items_sent + TAIL_ITEMS;
        while (items_sent < stop_at)
            send_fragment();
        send_text("+12");
        send_end();

        drain();
        repeat (8) @(posedge aclk);

        $display("lexed %0d bytes in %0d texts: directed corners, random token streams, %s",
                 board.bytes_lexed, board.texts_closed, "back-to-back tail");
        $display("checked %0d tokens, %0d mismatches, %0d tokens still pending",
                 board.tokens_checked, board.mismatches, board.expected_tokens.size());
        if (board.mismatches == 0 && board.expected_tokens.size() == 0) begin
            $display("c_subset_lexer_tb OK");
        end else begin
            $display("c_subset_lexer_tb NOT OK");
        end
        $finish;
    end

endmodule
